### rtl/ppt_pkg.sv
// Package for the point-in-polygon test block: sizes, command codes and the
// structs passed along the chain of edge cells. No dependencies.
package ppt_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int CoordW       = 32;
  localparam int DiffW        = CoordW + 1;
  localparam int ProdW        = 2 * DiffW;
  localparam int CountW       = 7;
  localparam int VertexIdxW   = 6;

  // One cell per vertex plus the cell that closes the ring.
  localparam int NumCells     = MAX_VERTICES + 1;
  localparam int StagesPerCell = 2;
  // Transactions in flight: every chain stage plus the output register.
  localparam int MaxInFlight  = NumCells * StagesPerCell + 1;
  localparam int InFlightW    = $clog2(MaxInFlight + 1);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  // Query token moving along the chain.
  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] prev_x;
    logic signed [CoordW-1:0] prev_y;
    logic                     parity;
  } tok_t;

  // Static role of one cell for the current vertex count.
  typedef struct packed {
    logic origin;   // loads its vertex as the previous vertex, tests no edge
    logic edge_en;  // tests the edge from the previous vertex to its own
  } cell_ctrl_t;

endpackage

### rtl/ppt_if.sv
// Valid/ready channel interfaces for the point-in-polygon test block.
// Depends on ppt_pkg for the coordinate and index widths.
interface ppt_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  command;
  logic [ppt_pkg::VertexIdxW-1:0]        vertex_index;
  logic signed [ppt_pkg::CoordW-1:0]     coord_x;
  logic signed [ppt_pkg::CoordW-1:0]     coord_y;

  modport source (output valid, command, vertex_index, coord_x, coord_y, input ready);
  modport sink   (input valid, command, vertex_index, coord_x, coord_y, output ready);
endinterface

interface ppt_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

### rtl/point_in_polygon_test_top.sv
// Top level of the point-in-polygon test block: vertex write and query
// channel, result channel, vertex count register and the chain of cells.
// Depends on ppt_pkg, ppt_if and ppt_edge_cell.
// Usage. Items arrive on in_i as valid/ready transactions. A write
// transaction (command 0) stores coord_x/coord_y as vertex vertex_index and
// gives no result. A query transaction (command 1) gives exactly one result
// on out_o: inside_res is 1 when the point lies inside the closed ring of
// vertices 0 .. vertex_count-1 by the even-odd crossing rule.
// The vertex count register is written through cfg_we_i/cfg_data_i while the
// block is idle; it resets to 3.
// Each vertex lives in its own cell. A query travels down a chain of 65
// cells, two register stages each: cell 0 loads vertex 0 as the previous
// vertex, cells 1 .. 63 test edges up to the vertex count, and the last cell
// holds a copy of vertex 0 and closes the ring. A query passes the register
// stages of every cell and then the output register; queries may enter back
// to back, one per cycle, while the chain is not frozen. A write is accepted
// only once every query in flight has delivered its result, so it never
// changes a query already under way. When the receiver holds ready low with a result
// waiting, the whole chain freezes and in_i stops accepting transactions.
// Reset empties the chain and the output register; vertices are undefined.
module point_in_polygon_test_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ppt_in_if.sink                       in_i,
  ppt_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [ppt_pkg::CountW-1:0]   cfg_data_i
);

  localparam int NumCells = ppt_pkg::NumCells;

  logic [ppt_pkg::CountW-1:0]    vcount_q;
  logic [ppt_pkg::CountW-1:0]    n_eff;
  logic [ppt_pkg::InFlightW-1:0] inflight_q, inflight_d;
  logic                          out_valid_q;
  logic                          out_inside_q;
  logic                          adv;
  logic                          is_query;
  logic                          in_acc, out_acc, wr_acc, q_acc;

  ppt_pkg::cell_ctrl_t ctrl  [NumCells];
  logic                wr_en [NumCells];
  logic                valid_c [NumCells+1];
  ppt_pkg::tok_t       tok_c   [NumCells+1];

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= ppt_pkg::CountW'(3);
    end else if (cfg_we_i) begin
      vcount_q <= cfg_data_i;
    end
  end

  // Counts above the store size use the whole store.
  assign n_eff = (int'(vcount_q) > ppt_pkg::MAX_VERTICES) ?
                 ppt_pkg::CountW'(ppt_pkg::MAX_VERTICES) : vcount_q;

  // The chain moves whenever the output register is free or being emptied.
  assign adv      = !out_valid_q || out_o.ready;
  assign is_query = (in_i.command == ppt_pkg::CMD_QUERY);
  assign in_i.ready = adv && (is_query || (inflight_q == '0));
  assign in_acc   = in_i.valid && in_i.ready;
  assign wr_acc   = in_acc && !is_query;
  assign q_acc    = in_acc && is_query;
  assign out_acc  = out_valid_q && out_o.ready;

  always_comb begin
    inflight_d = inflight_q;
    if (q_acc && !out_acc) begin
      inflight_d = inflight_q + 1'b1;
    end else if (!q_acc && out_acc) begin
      inflight_d = inflight_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // A query enters the first cell with a clear parity.
  always_comb begin
    valid_c[0]       = q_acc;
    tok_c[0].px      = in_i.coord_x;
    tok_c[0].py      = in_i.coord_y;
    tok_c[0].prev_x  = in_i.coord_x;
    tok_c[0].prev_y  = in_i.coord_y;
    tok_c[0].parity  = 1'b0;
  end

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    // The closing cell mirrors every write to vertex 0.
    localparam int Slot = (i == NumCells - 1) ? 0 : i;

    always_comb begin
      wr_en[i] = wr_acc && (int'(in_i.vertex_index) == Slot);
      if (i == 0) begin
        ctrl[i].origin  = 1'b1;
        ctrl[i].edge_en = 1'b0;
      end else if (i == NumCells - 1) begin
        ctrl[i].origin  = 1'b0;
        ctrl[i].edge_en = (n_eff != '0);
      end else begin
        ctrl[i].origin  = 1'b0;
        ctrl[i].edge_en = (int'(n_eff) > i);
      end
    end

    ppt_edge_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .ctrl_i  (ctrl[i]),
      .wr_en_i (wr_en[i]),
      .wr_x_i  (in_i.coord_x),
      .wr_y_i  (in_i.coord_y),
      .valid_i (valid_c[i]),
      .tok_i   (tok_c[i]),
      .valid_o (valid_c[i+1]),
      .tok_o   (tok_c[i+1])
    );
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= valid_c[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_inside_q <= tok_c[NumCells].parity;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.inside_res = out_inside_q;

endmodule

### rtl/ppt_edge_cell.sv
// One cell of the crossing-number chain: holds one vertex and tests one edge.
// Depends on ppt_pkg for the token and control structs.
module ppt_edge_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  ppt_pkg::cell_ctrl_t               ctrl_i,
  input  logic                              wr_en_i,
  input  logic signed [ppt_pkg::CoordW-1:0] wr_x_i,
  input  logic signed [ppt_pkg::CoordW-1:0] wr_y_i,
  input  logic                              valid_i,
  input  ppt_pkg::tok_t                     tok_i,
  output logic                              valid_o,
  output ppt_pkg::tok_t                     tok_o
);

  localparam int DiffW = ppt_pkg::DiffW;

  logic signed [ppt_pkg::CoordW-1:0] vx_q, vy_q;

  logic signed [ppt_pkg::DiffW-1:0]  a1, b1, a2, b2;
  logic signed [ppt_pkg::ProdW-1:0]  p1_d, p2_d;
  logic                              straddle;
  logic                              hit_d;
  ppt_pkg::tok_t                     a_tok_d;

  logic                              a_valid_q;
  ppt_pkg::tok_t                     a_tok_q;
  logic                              a_hit_q;
  logic                              a_dneg_q;
  logic signed [ppt_pkg::ProdW-1:0]  a_p1_q, a_p2_q;

  logic                              left;
  logic                              b_valid_q;
  ppt_pkg::tok_t                     b_tok_d;
  ppt_pkg::tok_t                     b_tok_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      vx_q <= wr_x_i;
      vy_q <= wr_y_i;
    end
  end

  // Stage A: straddle test and the two cross products of the exact compare.
  always_comb begin
    straddle = (vy_q > tok_i.py) != (tok_i.prev_y > tok_i.py);
    hit_d    = ctrl_i.edge_en && straddle;
    a1 = DiffW'(tok_i.px)     - DiffW'(vx_q);
    b1 = DiffW'(tok_i.prev_y) - DiffW'(vy_q);
    a2 = DiffW'(tok_i.prev_x) - DiffW'(vx_q);
    b2 = DiffW'(tok_i.py)     - DiffW'(vy_q);
    p1_d = ppt_pkg::ProdW'(a1) * ppt_pkg::ProdW'(b1);
    p2_d = ppt_pkg::ProdW'(a2) * ppt_pkg::ProdW'(b2);
    a_tok_d = tok_i;
    if (ctrl_i.origin || ctrl_i.edge_en) begin
      a_tok_d.prev_x = vx_q;
      a_tok_d.prev_y = vy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_tok_q  <= a_tok_d;
      a_hit_q  <= hit_d;
      a_dneg_q <= b1[DiffW-1];
      a_p1_q   <= p1_d;
      a_p2_q   <= p2_d;
    end
  end

  // Stage B: the point is left of the edge when the compare, flipped for an
  // upward edge (previous vertex below its own), holds; a hit toggles the parity.
  assign left = a_dneg_q ? (a_p1_q > a_p2_q) : (a_p1_q < a_p2_q);

  always_comb begin
    b_tok_d        = a_tok_q;
    b_tok_d.parity = a_tok_q.parity ^ (a_hit_q && left);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_tok_q <= b_tok_d;
    end
  end

  assign valid_o = b_valid_q;
  assign tok_o   = b_tok_q;

endmodule

### tb/point_in_polygon_test_checker.sv
`timescale 1ns / 1ps
// Result checker for the point-in-polygon test block: keeps its own vertex store and
// vertex count, predicts the inside flag of each query and compares it on the result
// channel. Depends on ppt_pkg and the channel interfaces of ppt_if.
module ppt_inside_checker
  import ppt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  ppt_in_if                 in_mon,
  ppt_out_if                out_mon,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_data_i,
  output int                mismatch_count_o,
  output int                expected_left_o
);

  logic signed [CoordW-1:0] ring_x [MAX_VERTICES];
  logic signed [CoordW-1:0] ring_y [MAX_VERTICES];
  logic [CountW-1:0]        ring_len = CountW'(3);
  bit                       inside_expected_q [$];

  // Even-odd crossing count over the closed ring, done exactly by cross-multiplying.
  function automatic bit point_is_inside(logic signed [CoordW-1:0] qx_in,
                                         logic signed [CoordW-1:0] qy_in);
    // 66 bits hold any product of two 33-bit differences together with its sign.
    logic signed [65:0] qx, qy, xi, yi, xj, yj, dy, lhs, rhs;
    int n;
    int i;
    int j;
    bit odd;
    n   = (ring_len > MAX_VERTICES) ? MAX_VERTICES : int'(ring_len);
    odd = 1'b0;
    qx  = 66'(qx_in);
    qy  = 66'(qy_in);
    j   = n - 1;
    for (i = 0; i < n; i++) begin
      xi = 66'(ring_x[i]);
      yi = 66'(ring_y[i]);
      xj = 66'(ring_x[j]);
      yj = 66'(ring_y[j]);
      if ((yi > qy) != (yj > qy)) begin
        dy  = yj - yi;
        lhs = (qx - xi) * dy;
        rhs = (xj - xi) * (qy - yi);
        if ((dy > 0) ? (lhs < rhs) : (lhs > rhs)) begin
          odd = ~odd;
        end
      end
      j = i;
    end
    return odd;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bit expected;
    if (!rst_ni) begin
      ring_len = CountW'(3);
      inside_expected_q.delete();
      mismatch_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        ring_len = cfg_data_i;
      end
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (inside_expected_q.size() == 0) begin
          $display("%0t: inside_res with no query waiting, expected none, actual %0b",
                   $time, out_mon.inside_res);
          mismatch_count_o++;
        end else begin
          expected = inside_expected_q.pop_front();
          if (out_mon.inside_res !== expected) begin
            $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                     $time, expected, out_mon.inside_res);
            mismatch_count_o++;
          end
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        if (in_mon.command == CMD_WRITE) begin
          ring_x[in_mon.vertex_index] = in_mon.coord_x;
          ring_y[in_mon.vertex_index] = in_mon.coord_y;
        end else begin
          inside_expected_q = {inside_expected_q,
                               point_is_inside(in_mon.coord_x, in_mon.coord_y)};
        end
      end
    end
    expected_left_o = inside_expected_q.size();
  end

endmodule

### tb/point_in_polygon_test_top_test.sv
`timescale 1ns / 1ps
// Testbench top for point_in_polygon_test_top: generates vertex writes, queries and
// vertex count settings, paces both channels and gives the verdict.
// Depends on ppt_pkg, ppt_if and the checker ppt_inside_checker.
module point_in_polygon_test_top_test;
  import ppt_pkg::*;

  // A little above the query latency, so the chain is surely empty.
  localparam int SETTLE_CYCLES     = 140;
  localparam int DRAIN_LIMIT       = 50000;
  localparam int NUM_PHASES        = 16;
  localparam int QUERIES_PER_PHASE = 12;
  // One phase sends a long unbroken run of queries while the receiver holds off,
  // which is more than the chain can hold.
  localparam int BURST_PHASE       = 9;
  localparam int BURST_QUERIES     = 150;
  localparam int HOLD_CYCLES       = 400;
  localparam int IDLE_GAP_MAX      = 7;
  localparam int COORD_MIN         = 32'sh8000_0000;
  localparam int COORD_MAX         = 32'sh7fff_ffff;

  // Coordinate ranges: a tiny grid makes ties on vertices and edges frequent, the
  // wider ranges exercise the full width of the products.
  typedef enum int {
    SCALE_TINY,
    SCALE_MID,
    SCALE_FULL
  } scale_e;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [CountW-1:0] cfg_data;

  int tx_gap_max;
  int rx_stall_max;
  bit hold_req;
  int mismatch_count;
  int expected_left;

  // Copy of the vertices written, used only to aim query points at the polygon.
  int shape_x [MAX_VERTICES];
  int shape_y [MAX_VERTICES];

  ppt_in_if  in_bus ();
  ppt_out_if out_bus ();

  point_in_polygon_test_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  ppt_inside_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_bus),
    .out_mon          (out_bus),
    .cfg_we_i         (cfg_we),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .expected_left_o  (expected_left)
  );

  always #1 clk_i = ~clk_i;

  // Hard stop in case the block hangs; the slowest correct run needs far less.
  initial begin : watchdog
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side. Before each transaction the receiver draws a number of cycles to keep
  // ready low, and once in the run it holds off for a long stretch so that the chain
  // fills and the input channel is stalled.
  initial begin : result_sink
    int stall;
    bit held;
    held          = 1'b0;
    out_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req && !held) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end else begin
        stall = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
      end
      if (stall > 0) begin
        @(negedge clk_i);
        out_bus.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_bus.valid === 1'b1 && out_bus.ready === 1'b1));
    end
  end

  // Presents one transaction after a random gap and returns at the edge that takes it.
  // Valid is left high, so the next call may follow back to back; whoever stops
  // sending must lower it at the very next falling edge.
  task automatic send_item(cmd_e cmd, int idx, int x, int y);
    int gap;
    gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_bus.valid        <= 1'b1;
    in_bus.command      <= cmd;
    in_bus.vertex_index <= idx[VertexIdxW-1:0];
    in_bus.coord_x      <= x;
    in_bus.coord_y      <= y;
    if (cmd == CMD_WRITE) begin
      shape_x[idx[VertexIdxW-1:0]] = x;
      shape_y[idx[VertexIdxW-1:0]] = y;
    end
    do @(posedge clk_i); while (!(in_bus.valid === 1'b1 && in_bus.ready === 1'b1));
  endtask

  // Stops sending, waits for every outstanding result and then SETTLE_CYCLES more,
  // so that the vertex count may be changed safely.
  task automatic drain_and_settle();
    int k;
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    for (k = 0; k < DRAIN_LIMIT && expected_left != 0; k++) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_vertex_count(logic [CountW-1:0] value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic int rand_coord(scale_e scale);
    case (scale)
      SCALE_TINY: return $urandom_range(0, 16) - 8;
      SCALE_MID:  return $urandom_range(0, 1 << 21) - (1 << 20);
      default:    return $urandom();
    endcase
  endfunction

  // Writes vertices 0 .. m-1. A star-shaped ring walks round a square and pulls each
  // corner in by a random amount, which gives a concave but orderly polygon; otherwise
  // the vertices are scattered, and the ring usually crosses itself.
  task automatic write_shape(int m, scale_e scale, bit star);
    longint r, t, off, vx, vy;
    int k, side, pull;
    r = (scale == SCALE_TINY) ? 8 : (scale == SCALE_MID) ? (1 << 20) : (1 << 30);
    for (k = 0; k < m; k++) begin
      if (star) begin
        t    = (longint'(k) * 8 * r) / m;
        side = int'(t / (2 * r));
        off  = t % (2 * r) - r;
        case (side)
          0: begin
            vx = off;
            vy = -r;
          end
          1: begin
            vx = r;
            vy = off;
          end
          2: begin
            vx = -off;
            vy = r;
          end
          default: begin
            vx = -r;
            vy = -off;
          end
        endcase
        pull = $urandom_range(2, 8);
        vx   = vx * pull / 8;
        pull = $urandom_range(2, 8);
        vy   = vy * pull / 8;
        send_item(CMD_WRITE, k, int'(vx), int'(vy));
      end else begin
        send_item(CMD_WRITE, k, rand_coord(scale), rand_coord(scale));
      end
    end
  endtask

  // Query points are mostly aimed at the polygon: on vertex coordinates, where the
  // straddle test and the cross-product compare meet their ties, or near the middle of
  // a chord. The rest are scattered or sit on the corners of the coordinate range.
  task automatic send_query(int m, scale_e scale);
    int a, b, sel, jitter, px, py;
    a      = (m > 0) ? $urandom_range(0, m - 1) : 0;
    b      = (m > 0) ? $urandom_range(0, m - 1) : 0;
    sel    = $urandom_range(0, 19);
    jitter = (scale == SCALE_TINY) ? int'($urandom_range(0, 2)) - 1 : 0;
    if (sel == 0) begin
      px = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      py = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
    end else if (sel < 3) begin
      px = $urandom();
      py = $urandom();
    end else if (sel < 8) begin
      px = shape_x[a];
      py = shape_y[b];
    end else if (sel < 16) begin
      px = int'((longint'(shape_x[a]) + shape_x[b]) / 2) + jitter;
      py = int'((longint'(shape_y[a]) + shape_y[b]) / 2);
    end else begin
      px = rand_coord(scale);
      py = rand_coord(scale);
    end
    send_item(CMD_QUERY, $urandom_range(0, MAX_VERTICES - 1), px, py);
  endtask

  initial begin : stimulus
    int ph, n, m, q, nq;
    scale_e scale;
    bit star, burst;

    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    tx_gap_max          = IDLE_GAP_MAX;
    rx_stall_max        = IDLE_GAP_MAX;
    hold_req            = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.command      = CMD_WRITE;
    in_bus.vertex_index = '0;
    in_bus.coord_x      = '0;
    in_bus.coord_y      = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. A triangle spanning the whole coordinate range is queried at the
    // reset vertex count of three: corners of the range, points on its vertices, and
    // points either side of its slanted edges at y = 0, where the products need every
    // bit of their width.
    send_item(CMD_WRITE, 0, COORD_MIN, COORD_MIN);
    send_item(CMD_WRITE, 1, COORD_MAX, COORD_MIN);
    send_item(CMD_WRITE, 2, 0, COORD_MAX);
    send_item(CMD_QUERY, 0, 0, 0);
    send_item(CMD_QUERY, 63, COORD_MIN, COORD_MIN);
    send_item(CMD_QUERY, 63, COORD_MAX, COORD_MAX);
    send_item(CMD_QUERY, 21, COORD_MIN, COORD_MAX);
    send_item(CMD_QUERY, 42, COORD_MAX, COORD_MIN);
    send_item(CMD_QUERY, 0, 0, COORD_MIN);
    send_item(CMD_QUERY, 0, -1, COORD_MAX - 1);
    send_item(CMD_QUERY, 0, 32'sh3fff_ffff, 0);
    send_item(CMD_QUERY, 0, 32'sh4000_0000, 0);
    send_item(CMD_QUERY, 0, -32'sh4000_0000, 0);
    send_item(CMD_QUERY, 0, -32'sh3fff_ffff, 0);
    send_item(CMD_QUERY, 0, -1, -1);

    // Phases. Each one changes the vertex count while the block is idle, writes a
    // fresh ring over the vertices it uses and then sends queries. The first phases
    // cover the empty ring, the single degenerate edge, the doubled segment, counts
    // above the store size and the smallest and largest proper rings.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_and_settle();
      burst = (ph == BURST_PHASE);
      case (ph)
        0: n = 0;
        1: n = 1;
        2: n = 2;
        3: n = 127;
        4: n = 64;
        5: n = 3;
        6: n = 65;
        default: begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 64) : $urandom_range(3, 16);
        end
      endcase
      m     = (n > MAX_VERTICES) ? MAX_VERTICES : n;
      scale = scale_e'($urandom_range(0, 2));
      star  = ($urandom_range(0, 3) != 0);
      // Some phases run with no idling on one side or both.
      tx_gap_max   = (burst || $urandom_range(0, 3) == 0) ? 0 : IDLE_GAP_MAX;
      rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_GAP_MAX;
      write_vertex_count(n[CountW-1:0]);
      write_shape(m, scale, star);
      if (burst) begin
        hold_req = 1'b1;
      end
      nq = burst ? BURST_QUERIES : QUERIES_PER_PHASE;
      for (q = 0; q < nq; q++) begin
        // Now and then a vertex is rewritten amid the queries; the block must hold
        // the write back until the queries ahead of it have finished.
        if (!burst && $urandom_range(0, 11) == 0) begin
          send_item(CMD_WRITE, $urandom_range(0, MAX_VERTICES - 1),
                    rand_coord(scale), rand_coord(scale));
        end
        send_query(m, scale);
      end
    end
    drain_and_settle();

    if (mismatch_count == 0 && expected_left == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### point_in_polygon_test_top.f
rtl/ppt_pkg.sv
rtl/ppt_if.sv
rtl/ppt_edge_cell.sv
rtl/point_in_polygon_test_top.sv
tb/point_in_polygon_test_checker.sv
tb/point_in_polygon_test_top_test.sv
